// File: hdl/gn2d_pkg.sv
// Shared types, constants and the divider step for the gradient noise block.
`timescale 1ns / 1ps
`default_nettype none

package gn2d_pkg;

  // Default sizes of the lattice and of its gradient store.
  localparam int DEF_MAX_SIDE    = 32;
  localparam int DEF_TABLE_DEPTH = 1024;

  // Field widths.
  localparam int PW  = 24;        // point and cell size width, 8 fraction bits
  localparam int FB  = 14;        // fraction bits of the cell fraction and result
  localparam int QW  = PW + FB;   // quotient of point * 2^14 / cell size
  localparam int TW  = FB + 1;    // fraction 0 .. 1.0 inclusive
  localparam int GW  = 16;        // one gradient component
  localparam int EIW = 10;        // entry index width
  localparam int CIW = 2;         // register index width
  localparam int CDW = 24;        // register data width

  // Item kinds.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  // Register indexes.
  localparam logic [CIW-1:0] REG_GRID_SIDE   = 2'd0;
  localparam logic [CIW-1:0] REG_CELL_WIDTH  = 2'd1;
  localparam logic [CIW-1:0] REG_CELL_HEIGHT = 2'd2;

  // Item fields that travel beside the arithmetic.
  typedef struct packed {
    logic           action;
    logic [EIW-1:0] entry_index;
    logic [GW-1:0]  grad_x;
    logic [GW-1:0]  grad_y;
  } side_t;

  // Partial remainder and the shifting dividend/quotient word.
  typedef struct packed {
    logic [PW-1:0] rem;
    logic [QW-1:0] w;
  } div_t;

  // One restoring division step: one quotient bit.
  function automatic div_t div_step(div_t d, logic [PW-1:0] s);
    logic [PW:0] t;
    div_t        o;
    t   = {d.rem, d.w[QW-1]};
    o.w = {d.w[QW-2:0], 1'b0};
    if (t >= {1'b0, s}) begin
      o.rem  = PW'(t - {1'b0, s});
      o.w[0] = 1'b1;
    end else begin
      o.rem = t[PW-1:0];
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// File: hdl/gn2d_div.sv
// Pipelined restoring divider for both axes: one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module gn2d_div (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire gn2d_pkg::side_t         in_side,
  input  wire logic [gn2d_pkg::PW-1:0] in_px,
  input  wire logic [gn2d_pkg::PW-1:0] in_py,
  input  wire logic [gn2d_pkg::PW-1:0] div_x,
  input  wire logic [gn2d_pkg::PW-1:0] div_y,
  output logic                         out_valid,
  output gn2d_pkg::side_t              out_side,
  output logic [gn2d_pkg::QW-1:0]      out_qx,
  output logic [gn2d_pkg::QW-1:0]      out_qy
);

  localparam int NS = gn2d_pkg::QW;

  logic             vld [NS];
  gn2d_pkg::side_t  sd  [NS];
  gn2d_pkg::div_t   dx  [NS];
  gn2d_pkg::div_t   dy  [NS];
  gn2d_pkg::div_t   x0;
  gn2d_pkg::div_t   y0;

  // The dividend is the point scaled by 2^14, so the quotient carries the fraction too.
  assign x0.rem = '0;
  assign x0.w   = {in_px, {gn2d_pkg::FB{1'b0}}};
  assign y0.rem = '0;
  assign y0.w   = {in_py, {gn2d_pkg::FB{1'b0}}};

  for (genvar k = 0; k < NS; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (en) begin
          vld[k] <= in_valid;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          sd[k] <= in_side;
          dx[k] <= gn2d_pkg::div_step(x0, div_x);
          dy[k] <= gn2d_pkg::div_step(y0, div_y);
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (en) begin
          vld[k] <= vld[k-1];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          sd[k] <= sd[k-1];
          dx[k] <= gn2d_pkg::div_step(dx[k-1], div_x);
          dy[k] <= gn2d_pkg::div_step(dy[k-1], div_y);
        end
      end
    end
  end

  assign out_valid = vld[NS-1];
  assign out_side  = sd[NS-1];
  assign out_qx    = dx[NS-1].w;
  assign out_qy    = dy[NS-1].w;

endmodule

`default_nettype wire

// File: hdl/gradient_noise_2d.sv
// Top level of the 2D gradient noise generator with quintic fade.
//
// Items arrive on the s_ stream. An item with tuser low (load) writes one
// gradient into the lattice table; an item with tuser high (evaluate) returns
// one noise value on the m_ stream. Registers are written on the cfg channel,
// which is always ready; the user must write them only while no item is in
// flight, as the block does not enforce it. Throughput is one item per cycle
// while s_tready is high. A result appears on m_tvalid after its item passes
// 38 stages of the bit-per-stage cell divider and 13 stages of address, table
// read, fade and blend, and then lands in the output register.
// A load reaches the table after the divider and stages A to D, in order with
// the evaluates around it, so an evaluate sees exactly the loads accepted before it.
// Reset empties the pipeline and sets grid_side to 32 and both cell sizes to
// 4096; the table holds no defined value until loaded.
// When the receiver stalls with a result waiting, the pipeline keeps moving
// until the next result reaches its last stage; only then does s_tready fall.
// Lattice point (i, j) is table entry i * side + j, wrapped to the table size.
`timescale 1ns / 1ps
`default_nettype none

module gradient_noise_2d #(
  parameter int MAX_SIDE    = gn2d_pkg::DEF_MAX_SIDE,
  parameter int TABLE_DEPTH = gn2d_pkg::DEF_TABLE_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  // entry_index[9:0], grad_x[25:10], grad_y[41:26], point_x[65:42],
  // point_y[89:66], zero padding[95:90]
  input  wire logic [95:0]              s_tdata,
  // action[0]
  input  wire logic                     s_tuser,
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  // noise_value[15:0]
  output logic [15:0]                   m_tdata,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [gn2d_pkg::CIW-1:0] cfg_index,
  input  wire logic [gn2d_pkg::CDW-1:0] cfg_data
);

  localparam int PW   = gn2d_pkg::PW;
  localparam int FB   = gn2d_pkg::FB;
  localparam int TW   = gn2d_pkg::TW;
  localparam int GW   = gn2d_pkg::GW;
  localparam int CW   = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
  localparam int SW   = $clog2(MAX_SIDE + 1);
  localparam int AW   = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int TIW  = $clog2(TABLE_DEPTH);
  // Wrapping by the table size uses a reciprocal that is exact for every address.
  localparam int RK    = AW + TIW + 1;
  localparam int RECIP = (2 ** RK + TABLE_DEPTH - 1) / TABLE_DEPTH;
  localparam int PRW   = AW + RK + 1;

  // ---------------------------------------------------------------- registers
  logic [5:0]    grid_side;
  logic [PW-1:0] cell_width;
  logic [PW-1:0] cell_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side   <= 6'd32;
      cell_width  <= 24'd4096;
      cell_height <= 24'd4096;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gn2d_pkg::REG_GRID_SIDE:   grid_side   <= cfg_data[5:0];
        gn2d_pkg::REG_CELL_WIDTH:  cell_width  <= cfg_data;
        gn2d_pkg::REG_CELL_HEIGHT: cell_height <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [SW-1:0] side_c;
  logic [CW-1:0] lim;
  logic [PW-1:0] div_x;
  logic [PW-1:0] div_y;

  always_comb begin
    if (grid_side < 6'd2) begin
      side_c = SW'(2);
    end else if (int'(grid_side) > MAX_SIDE) begin
      side_c = SW'(MAX_SIDE);
    end else begin
      side_c = SW'(grid_side);
    end
  end

  assign lim   = CW'(side_c - SW'(2));
  assign div_x = (cell_width == '0) ? PW'(1) : cell_width;
  assign div_y = (cell_height == '0) ? PW'(1) : cell_height;

  // ---------------------------------------------------------------- pipeline control
  logic en;
  logic m_ev;

  assign en       = !(m_ev && m_tvalid && !m_tready);
  assign s_tready = en;

  gn2d_pkg::side_t in_side;
  assign in_side.action      = s_tuser;
  assign in_side.entry_index = s_tdata[9:0];
  assign in_side.grad_x      = s_tdata[25:10];
  assign in_side.grad_y      = s_tdata[41:26];

  logic                   dv_valid;
  gn2d_pkg::side_t        dv_side;
  logic [gn2d_pkg::QW-1:0] dv_qx;
  logic [gn2d_pkg::QW-1:0] dv_qy;

  gn2d_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .in_side   (in_side),
    .in_px     (s_tdata[65:42]),
    .in_py     (s_tdata[89:66]),
    .div_x     (div_x),
    .div_y     (div_y),
    .out_valid (dv_valid),
    .out_side  (dv_side),
    .out_qx    (dv_qx),
    .out_qy    (dv_qy)
  );

  logic [gn2d_pkg::QW-1:0] dv_q [2];
  assign dv_q[0] = dv_qx;
  assign dv_q[1] = dv_qy;

  // ---------------------------------------------------------------- stage A: clamp
  logic            a_valid;
  gn2d_pkg::side_t a_side;
  logic [CW-1:0]   a_c [2];
  logic [TW-1:0]   a_f [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= dv_valid;
    end
  end

  // A cell past the last full cell is pinned to it with a fraction of one.
  always_ff @(posedge clk) begin
    if (en) begin
      a_side <= dv_side;
      for (int a = 0; a < 2; a++) begin
        if (dv_q[a][gn2d_pkg::QW-1:FB] > PW'(lim)) begin
          a_c[a] <= lim;
          a_f[a] <= TW'(1 << FB);
        end else begin
          a_c[a] <= CW'(dv_q[a][gn2d_pkg::QW-1:FB]);
          a_f[a] <= {1'b0, dv_q[a][FB-1:0]};
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage B
  logic            b_valid;
  gn2d_pkg::side_t b_side;
  logic [AW-1:0]   b_v   [4];
  logic [TW-1:0]   b_f   [2];
  logic [28:0]     b_t2  [2];
  logic [18:0]     b_t15 [2];
  logic [AW-1:0]   lu;

  assign lu = AW'(AW'(a_c[0]) * AW'(side_c)) + AW'(a_c[1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_side <= a_side;
      b_v[0] <= lu;
      b_v[1] <= lu + AW'(side_c);
      b_v[2] <= lu + AW'(side_c) + AW'(1);
      b_v[3] <= lu + AW'(1);
      for (int a = 0; a < 2; a++) begin
        b_f[a]   <= a_f[a];
        b_t2[a]  <= 29'(30'(a_f[a]) * 30'(a_f[a]));
        b_t15[a] <= 19'(a_f[a]) * 19'd15;
      end
    end
  end

  // ---------------------------------------------------------------- stage C
  logic            c_valid;
  gn2d_pkg::side_t c_side;
  logic [AW-1:0]   c_v  [4];
  logic [AW-1:0]   c_q  [4];
  logic [TW-1:0]   c_f  [2];
  logic [28:0]     c_t2 [2];
  logic [17:0]     c_i  [2];
  logic [32:0]     inner [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      inner[a] = 33'(b_t2[a]) * 33'd6 + (33'd10 << 28) - (33'(b_t15[a]) << FB);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_side <= b_side;
      for (int i = 0; i < 4; i++) begin
        c_v[i] <= b_v[i];
        c_q[i] <= AW'((PRW'(b_v[i]) * PRW'(RECIP)) >> RK);
      end
      for (int a = 0; a < 2; a++) begin
        c_f[a]  <= b_f[a];
        c_t2[a] <= b_t2[a];
        c_i[a]  <= inner[a][31:FB];
      end
    end
  end

  // ---------------------------------------------------------------- stage D
  logic            d_valid;
  gn2d_pkg::side_t d_side;
  logic [TIW-1:0]  d_addr [4];
  logic [TW-1:0]   d_f    [2];
  logic [28:0]     d_t2   [2];
  logic [32:0]     d_b    [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_side <= c_side;
      for (int i = 0; i < 4; i++) begin
        d_addr[i] <= TIW'(c_v[i] - AW'(c_q[i] * AW'(TABLE_DEPTH)));
      end
      for (int a = 0; a < 2; a++) begin
        d_f[a]  <= c_f[a];
        d_t2[a] <= c_t2[a];
        d_b[a]  <= 33'(c_f[a]) * 33'(c_i[a]);
      end
    end
  end

  // ---------------------------------------------------------------- stage E: table
  logic          e_ev;
  logic [31:0]   e_g  [4];
  logic [TW-1:0] e_f  [2];
  logic [45:0]   e_pl [2];
  logic [44:0]   e_ph [2];
  logic          wr_en;

  // Loads write here, where evaluates read, so table order follows item order.
  assign wr_en = en && d_valid && (d_side.action == gn2d_pkg::ACT_LOAD)
                 && (int'(d_side.entry_index) < TABLE_DEPTH);

  // One copy of the table per corner, all written together.
  for (genvar i = 0; i < 4; i++) begin : g_copy
    logic [31:0] mem [TABLE_DEPTH];
    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem[TIW'(d_side.entry_index)] <= {d_side.grad_y, d_side.grad_x};
      end
      if (en) begin
        e_g[i] <= mem[d_addr[i]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_ev <= 1'b0;
    end else if (en) begin
      e_ev <= d_valid && (d_side.action == gn2d_pkg::ACT_EVAL);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 2; a++) begin
        e_f[a]  <= d_f[a];
        e_pl[a] <= 46'(d_t2[a]) * 46'(d_b[a][16:0]);
        e_ph[a] <= 45'(d_t2[a]) * 45'(d_b[a][32:17]);
      end
    end
  end

  // ---------------------------------------------------------------- stage F: products
  logic               f_ev;
  logic signed [31:0] f_px [4];
  logic signed [31:0] f_py [4];
  logic [TW-1:0]      f_fade [2];
  logic signed [15:0] ofs_x [4];
  logic signed [15:0] ofs_y [4];
  logic [57:0]        fsum [2];

  always_comb begin
    // Corners in order: top left, top right, bottom right, bottom left.
    ofs_x[0] = $signed({1'b0, e_f[0]});
    ofs_x[3] = ofs_x[0];
    ofs_x[1] = ofs_x[0] - 16'sd16384;
    ofs_x[2] = ofs_x[1];
    ofs_y[0] = $signed({1'b0, e_f[1]});
    ofs_y[1] = ofs_y[0];
    ofs_y[2] = ofs_y[0] - 16'sd16384;
    ofs_y[3] = ofs_y[2];
    for (int a = 0; a < 2; a++) begin
      fsum[a] = 58'(e_pl[a]) + (58'(e_ph[a]) << 17) + (58'd1 << 41);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_ev <= 1'b0;
    end else if (en) begin
      f_ev <= e_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        f_px[i] <= $signed(e_g[i][GW-1:0]) * ofs_x[i];
        f_py[i] <= $signed(e_g[i][31:GW]) * ofs_y[i];
      end
      for (int a = 0; a < 2; a++) begin
        f_fade[a] <= fsum[a][56:42];
      end
    end
  end

  // ---------------------------------------------------------------- stage G: dots
  logic               g_ev;
  logic signed [31:0] g_dot [4];
  logic [TW-1:0]      g_fade [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      g_ev <= 1'b0;
    end else if (en) begin
      g_ev <= f_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        g_dot[i] <= f_px[i] + f_py[i];
      end
      g_fade <= f_fade;
    end
  end

  // ---------------------------------------------------------------- stage H
  logic               h_ev;
  logic signed [32:0] h_dt;
  logic signed [32:0] h_db;
  logic signed [31:0] h_lu;
  logic signed [31:0] h_ld;
  logic [TW-1:0]      h_fade [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      h_ev <= 1'b0;
    end else if (en) begin
      h_ev <= g_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_dt   <= 33'(g_dot[1]) - 33'(g_dot[0]);
      h_db   <= 33'(g_dot[2]) - 33'(g_dot[3]);
      h_lu   <= g_dot[0];
      h_ld   <= g_dot[3];
      h_fade <= g_fade;
    end
  end

  // ---------------------------------------------------------------- stage I
  logic               i_ev;
  logic signed [48:0] i_pt;
  logic signed [48:0] i_pb;
  logic signed [31:0] i_lu;
  logic signed [31:0] i_ld;
  logic [TW-1:0]      i_ty;

  always_ff @(posedge clk) begin
    if (rst) begin
      i_ev <= 1'b0;
    end else if (en) begin
      i_ev <= h_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i_pt <= h_dt * $signed({1'b0, h_fade[0]});
      i_pb <= h_db * $signed({1'b0, h_fade[0]});
      i_lu <= h_lu;
      i_ld <= h_ld;
      i_ty <= h_fade[1];
    end
  end

  // ---------------------------------------------------------------- stage J
  logic               j_ev;
  logic signed [32:0] j_up;
  logic signed [32:0] j_dn;
  logic [TW-1:0]      j_ty;
  logic signed [48:0] rt;
  logic signed [48:0] rb;

  assign rt = (i_pt + 49'sd8192) >>> FB;
  assign rb = (i_pb + 49'sd8192) >>> FB;

  always_ff @(posedge clk) begin
    if (rst) begin
      j_ev <= 1'b0;
    end else if (en) begin
      j_ev <= i_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      j_up <= 33'(i_lu) + 33'(rt);
      j_dn <= 33'(i_ld) + 33'(rb);
      j_ty <= i_ty;
    end
  end

  // ---------------------------------------------------------------- stage K
  logic               k_ev;
  logic signed [33:0] k_dv;
  logic signed [32:0] k_up;
  logic [TW-1:0]      k_ty;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_ev <= 1'b0;
    end else if (en) begin
      k_ev <= j_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k_dv <= 34'(j_dn) - 34'(j_up);
      k_up <= j_up;
      k_ty <= j_ty;
    end
  end

  // ---------------------------------------------------------------- stage L
  logic               l_ev;
  logic signed [49:0] l_p;
  logic signed [32:0] l_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      l_ev <= 1'b0;
    end else if (en) begin
      l_ev <= k_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l_p  <= k_dv * $signed({1'b0, k_ty});
      l_up <= k_up;
    end
  end

  // ---------------------------------------------------------------- stage M
  logic               m_r2_ev;
  logic signed [33:0] m_r2;
  logic signed [49:0] rv;

  assign rv   = (l_p + 50'sd8192) >>> FB;
  assign m_ev = m_r2_ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_r2_ev <= 1'b0;
    end else if (en) begin
      m_r2_ev <= l_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r2 <= 34'(l_up) + 34'(rv);
    end
  end

  // ---------------------------------------------------------------- output register
  logic signed [33:0] res;
  logic [15:0]        res_sat;

  assign res = (m_r2 + 34'sd8192) >>> FB;

  always_comb begin
    if (res > 34'sd32767) begin
      res_sat = 16'h7FFF;
    end else if (res < -34'sd32768) begin
      res_sat = 16'h8000;
    end else begin
      res_sat = res[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= (m_ev && en) || (m_tvalid && !m_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (en && m_ev) begin
      m_tdata <= res_sat;
    end
  end

endmodule

`default_nettype wire
